[rtl/lepm_pkg.sv]
// ----------------------------------------------------------------------------
// lepm_pkg: shared types and constants
// Register map, LFO shape codes, LFSR constants and the structs that pass
// between the control, the shared divider and the LFO back end.
// ----------------------------------------------------------------------------
`default_nettype none

package lepm_pkg;

	localparam int AddrW    = 5;
	localparam int DataW    = 32;
	localparam int DivSteps = 16;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] RegShape     = 3'd0;
	localparam logic [2:0] RegLfoPeriod = 3'd1;
	localparam logic [2:0] RegLfoDepth  = 3'd2;
	localparam logic [2:0] RegEnvPeriod = 3'd3;
	localparam logic [2:0] RegEnvWidth  = 3'd4;
	localparam logic [2:0] RegBasePitch = 3'd5;
	localparam logic [2:0] RegMidi      = 3'd6;

	// LFO shapes
	localparam logic [2:0] ShapeTri      = 3'd0;
	localparam logic [2:0] ShapeSawUp    = 3'd1;
	localparam logic [2:0] ShapeSawDown  = 3'd2;
	localparam logic [2:0] ShapeSquare   = 3'd3;
	localparam logic [2:0] ShapeQuarter  = 3'd4;
	localparam logic [2:0] ShapeHalfUp   = 3'd5;
	localparam logic [2:0] ShapeHalfDown = 3'd6;
	localparam logic [2:0] ShapeRandom   = 3'd7;

	localparam logic [15:0] LfsrSeed       = 16'hACE1;
	localparam logic [15:0] LfsrTaps       = 16'hB400;
	localparam logic [15:0] KnobOffset     = 16'd200;
	localparam logic [15:0] BasePitchReset = 16'd400;

	typedef struct packed {
		logic [2:0]  lfo_shape;
		logic [7:0]  lfo_period;
		logic [7:0]  lfo_depth;
		logic [7:0]  env_period;
		logic [7:0]  env_width;
		logic [15:0] base_pitch;
		logic        midi_mode;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [7:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [15:0] quot;
		logic [7:0]  rem;
	} div_rsp_t;

endpackage

`default_nettype wire

[rtl/lfo_envelope_pitch_modulator_core.sv]
// ----------------------------------------------------------------------------
// lfo_envelope_pitch_modulator_core: multi-shape LFO with envelope gate
// Per control tick: LFO level update, LFO/envelope phase advance, pitch
// compare word and change flag. Register block with slope recompute.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  tick    | in        | tick_valid / tick_stall   | tick
//  result  | out       | res_valid / res_stall     | pitch_word, pitch_changed,
//          |           |                           | env_gate, lfo_value,
//          |           |                           | lfo_first_half
//  config  | in        | APB psel/penable/pready   | paddr, pwdata, prdata
//
//  In the back end a tick is popped (phase times slope registered), passes
//  S_MUL and is decoded and finished in S_FIN; a random-shape draw with
//  nonzero depth also waits in S_DIV for the 16-step divider.
//  Each register write restarts the slope division (depth*256/period), or
//  clears the slope for a zero period: the tick channel stalls meanwhile.
//  The front queue holds up to QUEUE_DEPTH ticks, so intake keeps going while
//  a result waits on res_stall. Reset is asynchronous and restores control state only.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_envelope_pitch_modulator_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// tick channel
	input  wire                          tick_valid,
	output logic                         tick_stall,
	input  wire                          tick,
	// result channel
	output logic                         res_valid,
	input  wire                          res_stall,
	output logic [15:0]                  pitch_word,
	output logic                         pitch_changed,
	output logic                         env_gate,
	output logic [7:0]                   lfo_value,
	output logic                         lfo_first_half,
	// register port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [lepm_pkg::AddrW-1:0]   paddr,
	input  wire  [lepm_pkg::DataW-1:0]   pwdata,
	output logic [lepm_pkg::DataW-1:0]   prdata,
	output logic                         pready
);

	lepm_pkg::cfg_t     cfg_q;
	lepm_pkg::div_req_t back_req;
	lepm_pkg::div_req_t div_req;
	lepm_pkg::div_rsp_t div_rsp;

	logic [15:0] slope_q;
	logic        pending_q;
	logic        owner_q;
	logic        cfg_busy;
	logic        wr;
	logic        recalc;
	logic        slope_go;
	logic [2:0]  idx;
	logic        avail;
	logic        pop;

	assign pready = 1'b1;

	always_comb begin
		idx    = paddr[4:2];
		wr     = psel & penable & pwrite & pready;
		// any write inside the map recomputes the slope
		recalc = wr && (idx <= lepm_pkg::RegMidi);
		// slope owns the divider while pending or running
		cfg_busy = pending_q | owner_q;
		slope_go = pending_q && !div_rsp.busy && !back_req.start;

		if (slope_go && (cfg_q.lfo_period != 8'd0)) begin
			div_req.start    = 1'b1;
			div_req.dividend = {cfg_q.lfo_depth, 8'd0};
			div_req.divisor  = cfg_q.lfo_period;
		end else begin
			div_req = back_req;
		end

		case (idx)
			lepm_pkg::RegShape:     prdata = {29'd0, cfg_q.lfo_shape};
			lepm_pkg::RegLfoPeriod: prdata = {24'd0, cfg_q.lfo_period};
			lepm_pkg::RegLfoDepth:  prdata = {24'd0, cfg_q.lfo_depth};
			lepm_pkg::RegEnvPeriod: prdata = {24'd0, cfg_q.env_period};
			lepm_pkg::RegEnvWidth:  prdata = {24'd0, cfg_q.env_width};
			lepm_pkg::RegBasePitch: prdata = {16'd0, cfg_q.base_pitch};
			lepm_pkg::RegMidi:      prdata = {31'd0, cfg_q.midi_mode};
			default:                prdata = '0;
		endcase
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lfo_shape  <= lepm_pkg::ShapeTri;
			cfg_q.lfo_period <= '0;
			cfg_q.lfo_depth  <= '0;
			cfg_q.env_period <= '0;
			cfg_q.env_width  <= '0;
			cfg_q.base_pitch <= lepm_pkg::BasePitchReset;
			cfg_q.midi_mode  <= 1'b0;
		end else if (wr) begin
			case (idx)
				lepm_pkg::RegShape:     cfg_q.lfo_shape  <= pwdata[2:0];
				lepm_pkg::RegLfoPeriod: cfg_q.lfo_period <= pwdata[7:0];
				lepm_pkg::RegLfoDepth:  cfg_q.lfo_depth  <= pwdata[7:0];
				lepm_pkg::RegEnvPeriod: cfg_q.env_period <= pwdata[7:0];
				lepm_pkg::RegEnvWidth:  cfg_q.env_width  <= pwdata[7:0];
				lepm_pkg::RegBasePitch: cfg_q.base_pitch <= pwdata[15:0];
				lepm_pkg::RegMidi:      cfg_q.midi_mode  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// slope recompute: hold a request until the divider is free, then
	// launch it (or clear the slope outright for a zero period)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			owner_q   <= 1'b0;
			slope_q   <= '0;
		end else begin
			pending_q <= recalc | (pending_q & ~slope_go);
			if (slope_go) begin
				if (cfg_q.lfo_period == 8'd0) begin
					// drop any division still owned from an earlier write
					slope_q <= '0;
					owner_q <= 1'b0;
				end else begin
					owner_q <= 1'b1;
				end
			end else if (owner_q && div_rsp.done) begin
				slope_q <= div_rsp.quot;
				owner_q <= 1'b0;
			end
		end
	end

	lepm_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick       (tick),
		.tick_stall (tick_stall),
		.cfg_busy   (cfg_busy),
		.pop        (pop),
		.avail      (avail)
	);

	lepm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lepm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.slope          (slope_q),
		.cfg_busy       (cfg_busy),
		.avail          (avail),
		.pop            (pop),
		.div_req        (back_req),
		.div_rsp        (div_rsp),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.pitch_word     (pitch_word),
		.pitch_changed  (pitch_changed),
		.env_gate       (env_gate),
		.lfo_value      (lfo_value),
		.lfo_first_half (lfo_first_half)
	);

endmodule

`default_nettype wire

[rtl/lepm_div.sv]
// ----------------------------------------------------------------------------
// lepm_div: iterative restoring divider
// 16-bit dividend by 8-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lepm_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lepm_pkg::div_req_t  req,
	output lepm_pkg::div_rsp_t  rsp
);

	localparam int CntW = $clog2(lepm_pkg::DivSteps);

	logic [7:0]      rem_q;
	logic [15:0]     quot_q;
	logic [7:0]      divisor_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [8:0] trial;
	logic       ge;
	logic [8:0] diff;

	always_comb begin
		trial = {rem_q, quot_q[15]};
		ge    = trial >= {1'b0, divisor_q};
		diff  = trial - {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CntW'(lepm_pkg::DivSteps - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(lepm_pkg::DivSteps - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: load on start, shift one quotient bit in per step
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quot_q    <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[7:0] : trial[7:0];
			quot_q <= {quot_q[14:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

[rtl/lepm_front.sv]
// ----------------------------------------------------------------------------
// lepm_front: tick intake and pending-tick queue
// Accepts tick transactions, drops idle ticks and queues real ones.
// ----------------------------------------------------------------------------
`default_nettype none

module lepm_front #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  tick_valid,
	input  wire  tick,
	output logic tick_stall,
	input  wire  cfg_busy,
	input  wire  pop,
	output logic avail
);

	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	logic [CntW-1:0] cnt_q;
	logic            full;
	logic            push;

	always_comb begin
		full       = cnt_q == CntW'(QUEUE_DEPTH);
		tick_stall = full | cfg_busy;
		// a tick of 0 is accepted and dropped
		push       = tick_valid & ~tick_stall & tick;
		avail      = cnt_q != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

[rtl/lepm_back.sv]
// ----------------------------------------------------------------------------
// lepm_back: LFO, envelope and pitch word engine
// Runs one queued tick at a time and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lepm_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lepm_pkg::cfg_t      cfg,
	input  wire  [15:0]         slope,
	input  wire                 cfg_busy,
	input  wire                 avail,
	output logic                pop,
	output lepm_pkg::div_req_t  div_req,
	input  lepm_pkg::div_rsp_t  div_rsp,
	output logic                res_valid,
	input  wire                 res_stall,
	output logic [15:0]         pitch_word,
	output logic                pitch_changed,
	output logic                env_gate,
	output logic [7:0]          lfo_value,
	output logic                lfo_first_half
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]  state_q;
	logic [7:0]  lfo_phase_q;
	logic [7:0]  lfo_level_q;
	logic [15:0] lfsr_q;
	logic [7:0]  env_phase_q;
	logic [15:0] last_pitch_q;
	logic [23:0] product_s1;
	logic        res_valid_q;

	logic [7:0]  half;
	logic [7:0]  quarter;
	logic        first;
	logic [15:0] r8_raw;
	logic [16:0] r7_raw;
	logic [7:0]  r8;
	logic [7:0]  r7;
	logic [15:0] lfsr_next;
	logic        random_draw;
	logic [7:0]  level_next;
	logic [7:0]  phase_inc;
	logic [7:0]  phase_next;
	logic [7:0]  env_inc;
	logic [7:0]  env_next;
	logic [15:0] word;
	logic        fin_go;

	always_comb begin
		half        = cfg.lfo_period >> 1;
		quarter     = cfg.lfo_period >> 2;
		first       = lfo_phase_q < half;
		r8_raw      = product_s1[23:8];
		r7_raw      = product_s1[23:7];
		// saturate a stale-phase ramp at the depth
		r8          = (r8_raw > {8'd0, cfg.lfo_depth}) ? cfg.lfo_depth : r8_raw[7:0];
		r7          = (r7_raw > {9'd0, cfg.lfo_depth}) ? cfg.lfo_depth : r7_raw[7:0];
		lfsr_next   = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? lepm_pkg::LfsrTaps : 16'd0);
		random_draw = (cfg.lfo_shape == lepm_pkg::ShapeRandom) && (lfo_phase_q == 8'd0);

		case (cfg.lfo_shape)
			lepm_pkg::ShapeTri:      level_next = first ? r8 : cfg.lfo_depth - r8;
			lepm_pkg::ShapeSawUp:    level_next = r8;
			lepm_pkg::ShapeSawDown:  level_next = cfg.lfo_depth - r8;
			lepm_pkg::ShapeSquare:   level_next = first ? 8'd0 : cfg.lfo_depth;
			lepm_pkg::ShapeQuarter:  level_next = (lfo_phase_q < quarter) ? cfg.lfo_depth : 8'd0;
			lepm_pkg::ShapeHalfUp:   level_next = first ? r7 : 8'd0;
			lepm_pkg::ShapeHalfDown: level_next = first ? cfg.lfo_depth - r7 : 8'd0;
			default: begin
				if (random_draw) begin
					level_next = (cfg.lfo_depth == 8'd0) ? 8'd0 : div_rsp.rem;
				end else begin
					level_next = lfo_level_q;
				end
			end
		endcase

		phase_inc  = lfo_phase_q + 8'd1;
		phase_next = (phase_inc >= cfg.lfo_period) ? 8'd0 : phase_inc;
		env_inc    = env_phase_q + 8'd1;
		env_next   = (env_inc >= cfg.env_period) ? 8'd0 : env_inc;

		if (cfg.midi_mode) begin
			word = cfg.base_pitch - {6'd0, level_next, 2'b00};
		end else begin
			word = lepm_pkg::KnobOffset + ((cfg.base_pitch - {8'd0, level_next}) << 2);
		end

		pop    = (state_q == S_IDLE) && avail && !cfg_busy;
		fin_go = (state_q == S_FIN) && (!res_valid_q || !res_stall);

		div_req.start    = (state_q == S_MUL) && random_draw && (cfg.lfo_depth != 8'd0);
		div_req.dividend = lfsr_next;
		div_req.divisor  = cfg.lfo_depth;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lfo_phase_q  <= '0;
			lfo_level_q  <= '0;
			lfsr_q       <= lepm_pkg::LfsrSeed;
			env_phase_q  <= '0;
			last_pitch_q <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && !fin_go) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (random_draw) begin
						lfsr_q <= lfsr_next;
					end
					state_q <= div_req.start ? S_DIV : S_FIN;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						lfo_level_q  <= level_next;
						lfo_phase_q  <= phase_next;
						env_phase_q  <= env_next;
						last_pitch_q <= word;
						res_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload: product on pop, results on completion
	always_ff @(posedge clk) begin
		if (pop) begin
			product_s1 <= {16'd0, lfo_phase_q} * {8'd0, slope};
		end
		if (fin_go) begin
			pitch_word     <= word;
			pitch_changed  <= word != last_pitch_q;
			env_gate       <= env_next <= cfg.env_width;
			lfo_value      <= level_next;
			lfo_first_half <= first;
		end
	end

	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

[rtl/lepm_checker.sv]
// ----------------------------------------------------------------------------
// lepm_checker: port-level assertions
// Watches the top level's ports; bound to the core below.
// ----------------------------------------------------------------------------
`default_nettype none

module lepm_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        tick_stall,
	input wire                        res_valid,
	input wire                        res_stall,
	input wire [15:0]                 pitch_word,
	input wire                        pitch_changed,
	input wire                        env_gate,
	input wire [7:0]                  lfo_value,
	input wire                        lfo_first_half,
	input wire                        psel,
	input wire                        penable,
	input wire                        pwrite,
	input wire [lepm_pkg::AddrW-1:0]  paddr
);

	logic [15:0] last_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_word_q <= '0;
		end else if (res_valid && !res_stall) begin
			last_word_q <= pitch_word;
		end
	end

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable({pitch_word, pitch_changed,
			env_gate, lfo_value, lfo_first_half}))
		else $error("result changed while stalled");

	// change flag tracks the previously delivered word
	a_changed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pitch_changed == (pitch_word != last_word_q))
		else $error("pitch_changed disagrees with previous word");

	// a register write holds off ticks while the slope is recomputed
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[4:2] <= lepm_pkg::RegMidi) |=> tick_stall)
		else $error("tick intake open during slope recompute");

endmodule

bind lfo_envelope_pitch_modulator_core lepm_checker u_lepm_checker (.*);

`default_nettype wire
